// ----- rtl/stlm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stlm_pkg
// Shared constants, command/status types and the quarter-wave sine table
// function of the single-bin tone level meter.
// ----------------------------------------------------------------------------
package stlm_pkg;

  localparam int unsigned MAX_WINDOW      = 65536;
  localparam int unsigned TRIG_TABLE_BITS = 10;
  localparam int unsigned QUARTER         = 1 << TRIG_TABLE_BITS;
  localparam int unsigned TI_W            = TRIG_TABLE_BITS + 1;
  localparam int unsigned WC_W            = $clog2(MAX_WINDOW + 1);
  localparam int unsigned ACC_W           = 32 + $clog2(MAX_WINDOW);
  localparam int unsigned HALF_W          = (ACC_W + 1) / 2;
  localparam int unsigned M_W             = 2 * ACC_W;
  localparam int unsigned NCNT_W          = $clog2(M_W);
  localparam int unsigned E_W             = 7;
  localparam int unsigned FRAC_BITS       = 24;
  localparam int unsigned LOG_W           = E_W + FRAC_BITS;
  localparam int unsigned SH_W            = $clog2(2 * HALF_W + 1);

  localparam logic [TI_W-1:0]    QTR         = TI_W'(QUARTER);
  localparam logic [WC_W-1:0]    WIN_MAX     = WC_W'(MAX_WINDOW);
  localparam logic signed [15:0] LEVEL_MIN   = -16'sd30720;
  localparam logic signed [15:0] LEVEL_MAX   = 16'sd1024;
  localparam logic [25:0]        DB_SCALE    = 26'd50504453;
  localparam logic [63:0]        HALF_PI_Q61 = 64'h3243F6A8885A308D;

  typedef enum logic {
    CFG_PHASE_INC = 1'b0,
    CFG_SKIP      = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic       take;
    logic       mul;
    logic       acc;
    logic       sq_clr;
    logic       sq_mul;
    logic       sq_add;
    logic [2:0] sq_step;
    logic       log_start;
    logic       log_sel_n;
    logic       lg;
    logic       pm;
    logic       rnd;
    logic       res_min;
    logic       out_load;
  } stlm_cmd_t;

  typedef struct packed {
    logic last;
    logic zero;
    logic log_done;
  } stlm_sts_t;

  function automatic logic [63:0] mul_q61(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[124:61];
  endfunction

  // taylor series sine, evaluated at elaboration only
  function automatic logic [15:0] trig_entry(int unsigned k);
    logic [63:0] ang;
    logic [63:0] sq;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] v;
    ang  = mul_q61(HALF_PI_Q61, 64'(k) << (61 - TRIG_TABLE_BITS));
    sq   = mul_q61(ang, ang);
    term = ang;
    acc  = ang;
    for (int unsigned j = 1; j <= 13; j++) begin
      term = mul_q61(term, sq) / 64'((2 * j) * (2 * j + 1));
      if ((j % 2) == 1) acc = acc - term;
      else              acc = acc + term;
    end
    v = (acc + (64'd1 << 45)) >> 46;
    return (v > 64'd32767) ? 16'd32767 : v[15:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/single_bin_tone_level_meter_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// single_bin_tone_level_meter_top
// Single-bin tone level meter: correlates PCM samples with a table sine and
// cosine and reports the tone level in 1/256 dBFS at the end of a window.
// ----------------------------------------------------------------------------
// each sample goes through table read, multiply and accumulate steps; the input stalls until the accumulate is done
// a last sample is followed by the energy sum, two iterative log2 runs and the dB math before the result shows,
// the normalize shifts of the iterative log2 unit being up to 95 per run
// an empty or silent window skips the energy and log steps and loads the minimum level after the accumulate
// reset clears sums, phase, counters and both config registers at once
module single_bin_tone_level_meter_top (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire                cfg_index_i,
  input  wire  [31:0]        cfg_wdata_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  signed [15:0] sample_i,
  input  wire                last_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [15:0] level_db_o
);
  import stlm_pkg::*;

  stlm_cmd_t cmd;
  stlm_sts_t sts;

  stlm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  stlm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .level_db_o  (level_db_o)
  );

endmodule
`default_nettype wire

// ----- rtl/stlm_log2.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stlm_log2
// Iterative log2: one-bit-per-cycle normalize, then 24 square steps for the
// fraction (a multiply state and an update state each).
// ----------------------------------------------------------------------------
module stlm_log2 (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  wire  [stlm_pkg::M_W-1:0]   val_i,
  output logic                       done_o,
  output logic [stlm_pkg::LOG_W-1:0] result_o
);
  import stlm_pkg::*;

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_NORM = 4'b0010,
    L_MUL  = 4'b0100,
    L_UPD  = 4'b1000
  } lst_e;

  lst_e              st_q, st_d;
  logic [M_W-1:0]    norm_q;
  logic [NCNT_W-1:0] cnt_q;
  logic [31:0]       m_q;
  logic [63:0]       sq_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic [4:0]        step_q;
  logic              done_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      L_IDLE: if (start_i) st_d = L_NORM;
      L_NORM: if (norm_q[M_W-1]) st_d = L_MUL;
      L_MUL:  st_d = L_UPD;
      L_UPD:  st_d = (step_q == 5'(FRAC_BITS - 1)) ? L_IDLE : L_MUL;
      default: st_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= L_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == L_UPD) && (step_q == 5'(FRAC_BITS - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      L_IDLE: begin
        if (start_i) begin
          norm_q <= val_i;
          cnt_q  <= '0;
        end
      end
      L_NORM: begin
        if (norm_q[M_W-1]) begin
          m_q    <= norm_q[M_W-1 -: 32];
          frac_q <= '0;
          step_q <= '0;
        end else begin
          norm_q <= norm_q << 1;
          cnt_q  <= cnt_q + 1'b1;
        end
      end
      L_MUL: sq_q <= {32'd0, m_q} * {32'd0, m_q};
      L_UPD: begin
        // mantissa squared, renormalize when it reaches two
        if (sq_q[63]) begin
          m_q    <= sq_q[63:32];
          frac_q <= {frac_q[FRAC_BITS-2:0], 1'b1};
        end else begin
          m_q    <= sq_q[62:31];
          frac_q <= {frac_q[FRAC_BITS-2:0], 1'b0};
        end
        step_q <= step_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign result_o = {E_W'(M_W - 1) - E_W'(cnt_q), frac_q};

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> st_q == L_IDLE) else $error("log2 started while busy");
  a_norm_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == L_NORM |-> norm_q != '0) else $error("log2 of zero");
  a_mul_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == L_MUL |=> st_q == L_UPD) else $error("square step lost");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> st_q == L_IDLE) else $error("done while busy");

endmodule
`default_nettype wire

// ----- rtl/stlm_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stlm_datapath
// Phase accumulator, sine table, correlation sums, energy, log and dB math.
// ----------------------------------------------------------------------------
module stlm_datapath (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire                     cfg_index_i,
  input  wire  [31:0]             cfg_wdata_i,
  input  wire  signed [15:0]      sample_i,
  input  wire                     last_i,
  input  stlm_pkg::stlm_cmd_t     cmd_i,
  output stlm_pkg::stlm_sts_t     sts_o,
  output logic signed [15:0]      level_db_o
);
  import stlm_pkg::*;

  logic [15:0] tab [QUARTER+1];
  for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
    assign tab[k] = trig_entry(k);
  end

  logic [31:0]             inc_q;
  logic [15:0]             skip_cnt_q, skip_left_q;
  logic [31:0]             phase_q;
  logic signed [ACC_W-1:0] cos_q, sin_q;
  logic [WC_W-1:0]         wc_q;
  logic                    acc_en_q, last_q;
  logic signed [15:0]      sample_q;
  logic [1:0]              quad_q;
  logic [15:0]             tab_a_q, tab_b_q;
  logic signed [31:0]      pc_q, ps_q;
  logic [2*HALF_W-1:0]     sqp_q;
  logic [SH_W-1:0]         sh_q;
  logic [M_W-1:0]          m_q;
  logic [LOG_W-1:0]        lm_q, ln_q;
  logic signed [31:0]      lg_q;
  logic [41:0]             plo_q;
  logic signed [42:0]      phi_q;
  logic signed [15:0]      res_q, out_q;

  logic [TRIG_TABLE_BITS-1:0] idx;
  logic signed [15:0]      sv, cv, ta, tb;
  logic [ACC_W-1:0]        mag_c, mag_s;
  logic [2*HALF_W-1:0]     pad_c, pad_s;
  logic [HALF_W-1:0]       op_a, op_b;
  logic [SH_W-1:0]         op_sh;
  logic [M_W-1:0]          log_in;
  logic [LOG_W-1:0]        log_res;
  logic                    log_done;
  logic signed [33:0]      lg_w;
  logic signed [58:0]      prod_w;
  logic signed [18:0]      r_w;
  logic                    restart;

  assign idx = phase_q[29 -: TRIG_TABLE_BITS];
  assign ta  = $signed(tab_a_q);
  assign tb  = $signed(tab_b_q);

  always_comb begin
    case (quad_q)
      2'd0:    begin sv = ta;  cv = tb;  end
      2'd1:    begin sv = tb;  cv = -ta; end
      2'd2:    begin sv = -ta; cv = -tb; end
      default: begin sv = -tb; cv = ta;  end
    endcase
  end

  assign mag_c = cos_q[ACC_W-1] ? ACC_W'(-cos_q) : ACC_W'(cos_q);
  assign mag_s = sin_q[ACC_W-1] ? ACC_W'(-sin_q) : ACC_W'(sin_q);
  assign pad_c = (2*HALF_W)'(mag_c);
  assign pad_s = (2*HALF_W)'(mag_s);

  // x^2 = hi*hi << 2h + 2*hi*lo << h + lo*lo
  always_comb begin
    case (cmd_i.sq_step)
      3'd0: begin op_a = pad_c[2*HALF_W-1 -: HALF_W]; op_b = op_a;
                  op_sh = SH_W'(2 * HALF_W); end
      3'd1: begin op_a = pad_c[HALF_W-1:0]; op_b = pad_c[2*HALF_W-1 -: HALF_W];
                  op_sh = SH_W'(HALF_W + 1); end
      3'd2: begin op_a = pad_c[HALF_W-1:0]; op_b = op_a; op_sh = '0; end
      3'd3: begin op_a = pad_s[2*HALF_W-1 -: HALF_W]; op_b = op_a;
                  op_sh = SH_W'(2 * HALF_W); end
      3'd4: begin op_a = pad_s[HALF_W-1:0]; op_b = pad_s[2*HALF_W-1 -: HALF_W];
                  op_sh = SH_W'(HALF_W + 1); end
      default: begin op_a = pad_s[HALF_W-1:0]; op_b = op_a; op_sh = '0; end
    endcase
  end

  assign log_in = cmd_i.log_sel_n ? M_W'(wc_q) : m_q;

  stlm_log2 u_log2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.log_start),
    .val_i    (log_in),
    .done_o   (log_done),
    .result_o (log_res)
  );

  assign lg_w   = 34'(lm_q) + 34'(1 << FRAC_BITS) - (34'(ln_q) << 1)
                - 34'(60 << FRAC_BITS);
  assign prod_w = (59'(phi_q) <<< 16) + $signed({17'd0, plo_q}) + (59'sd1 <<< 39);
  assign r_w    = prod_w[58:40];

  assign restart = cmd_i.out_load || (cfg_we_i && cfg_index_i == CFG_SKIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q       <= '0;
      skip_cnt_q  <= '0;
      skip_left_q <= '0;
      phase_q     <= '0;
      cos_q       <= '0;
      sin_q       <= '0;
      wc_q        <= '0;
      acc_en_q    <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_PHASE_INC) inc_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_index_i == CFG_SKIP) skip_cnt_q <= cfg_wdata_i[15:0];
      if (cmd_i.take) begin
        last_q <= last_i;
        if (skip_left_q != '0) begin
          skip_left_q <= skip_left_q - 1'b1;
          acc_en_q    <= 1'b0;
        end else if (wc_q < WIN_MAX) begin
          acc_en_q <= 1'b1;
          phase_q  <= phase_q + inc_q;
          wc_q     <= wc_q + 1'b1;
        end else begin
          acc_en_q <= 1'b0;
        end
      end
      if (cmd_i.acc && acc_en_q) begin
        cos_q <= cos_q + ACC_W'(pc_q);
        sin_q <= sin_q + ACC_W'(ps_q);
      end
      if (restart) begin
        skip_left_q <= (cfg_we_i && cfg_index_i == CFG_SKIP) ? cfg_wdata_i[15:0]
                                                              : skip_cnt_q;
        phase_q <= '0;
        cos_q   <= '0;
        sin_q   <= '0;
        wc_q    <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      sample_q <= sample_i;
      quad_q   <= phase_q[31:30];
      tab_a_q  <= tab[{1'b0, idx}];
      tab_b_q  <= tab[QTR - {1'b0, idx}];
    end
    if (cmd_i.mul) begin
      pc_q <= sample_q * cv;
      ps_q <= sample_q * sv;
    end
    if (cmd_i.sq_mul) begin
      sqp_q <= {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};
      sh_q  <= op_sh;
    end
    if (cmd_i.sq_clr) m_q <= '0;
    else if (cmd_i.sq_add) m_q <= m_q + (M_W'(sqp_q) << sh_q);
    if (log_done) begin
      if (cmd_i.log_sel_n) ln_q <= log_res;
      else                 lm_q <= log_res;
    end
    if (cmd_i.lg) lg_q <= lg_w[31:0];
    if (cmd_i.pm) begin
      plo_q <= {26'd0, lg_q[15:0]} * {16'd0, DB_SCALE};
      phi_q <= 43'($signed(lg_q[31:16])) * $signed({17'd0, DB_SCALE});
    end
    if (cmd_i.res_min) res_q <= LEVEL_MIN;
    else if (cmd_i.rnd) begin
      if (r_w < 19'(LEVEL_MIN))      res_q <= LEVEL_MIN;
      else if (r_w > 19'(LEVEL_MAX)) res_q <= LEVEL_MAX;
      else                           res_q <= r_w[15:0];
    end
    if (cmd_i.out_load) out_q <= res_q;
  end

  assign sts_o.last     = last_q;
  assign sts_o.zero     = (wc_q == '0) || (cos_q == '0 && sin_q == '0);
  assign sts_o.log_done = log_done;
  assign level_db_o     = out_q;

endmodule
`default_nettype wire

// ----- rtl/stlm_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stlm_ctrl
// Sequencer: per-sample lookup/multiply/accumulate and the end-of-window
// energy, log and dB steps; owns the input stall and output valid.
// ----------------------------------------------------------------------------
module stlm_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  input  stlm_pkg::stlm_sts_t sts_i,
  output stlm_pkg::stlm_cmd_t cmd_o
);
  import stlm_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_MUL   = 13'b0000000000010,
    S_ACC   = 13'b0000000000100,
    S_CHK   = 13'b0000000001000,
    S_SQ    = 13'b0000000010000,
    S_LOGM  = 13'b0000000100000,
    S_WAITM = 13'b0000001000000,
    S_LOGN  = 13'b0000010000000,
    S_WAITN = 13'b0000100000000,
    S_LG    = 13'b0001000000000,
    S_PM    = 13'b0010000000000,
    S_RND   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } st_e;

  st_e        st_q, st_d;
  logic [2:0] cnt_q, cnt_d;
  logic       ov_q, ov_d;
  logic       out_free;

  assign out_free = !ov_q || !out_stall_i;

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    cmd_o = '0;
    cmd_o.sq_step = cnt_q;
    case (st_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.take = 1'b1;
        st_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        st_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        st_d = sts_i.last ? S_CHK : S_IDLE;
      end
      S_CHK: begin
        if (sts_i.zero) begin
          cmd_o.res_min = 1'b1;
          st_d = S_OUT;
        end else begin
          cmd_o.sq_clr = 1'b1;
          cnt_d = '0;
          st_d = S_SQ;
        end
      end
      S_SQ: begin
        // multiply step k while adding step k-1
        cmd_o.sq_mul = (cnt_q != 3'd6);
        cmd_o.sq_add = (cnt_q != 3'd0);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 3'd6) st_d = S_LOGM;
      end
      S_LOGM: begin
        cmd_o.log_start = 1'b1;
        st_d = S_WAITM;
      end
      S_WAITM: if (sts_i.log_done) st_d = S_LOGN;
      S_LOGN: begin
        cmd_o.log_sel_n = 1'b1;
        cmd_o.log_start = 1'b1;
        st_d = S_WAITN;
      end
      S_WAITN: begin
        cmd_o.log_sel_n = 1'b1;
        if (sts_i.log_done) st_d = S_LG;
      end
      S_LG: begin
        cmd_o.lg = 1'b1;
        st_d = S_PM;
      end
      S_PM: begin
        cmd_o.pm = 1'b1;
        st_d = S_RND;
      end
      S_RND: begin
        cmd_o.rnd = 1'b1;
        st_d = S_OUT;
      end
      S_OUT: if (out_free) begin
        cmd_o.out_load = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    if (cmd_o.out_load) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
    end
  end

  assign in_stall_o  = (st_q != S_IDLE);
  assign out_valid_o = ov_q;

endmodule
`default_nettype wire
